@@ src/qse_pkg.sv @@
package qse_pkg;

  // Width of one element of the set.
  localparam int unsigned DATA_W = 32;

  // Sequencer states, one-hot.
  typedef enum logic [12:0] {
    ST_LOAD  = 13'b0000000000001,
    ST_POP   = 13'b0000000000010,
    ST_POPW  = 13'b0000000000100,
    ST_PIV   = 13'b0000000001000,
    ST_SCAN  = 13'b0000000010000,
    ST_SW1   = 13'b0000000100000,
    ST_SW2   = 13'b0000001000000,
    ST_FIN   = 13'b0000010000000,
    ST_FIN2  = 13'b0000100000000,
    ST_PUSH1 = 13'b0001000000000,
    ST_PUSH2 = 13'b0010000000000,
    ST_ORD   = 13'b0100000000000,
    ST_OLD   = 13'b1000000000000
  } state_t;

endpackage

@@ src/quicksort_engine.sv @@
// quicksort_engine: collects a set of signed 32-bit values, sorts them in
// ascending order and streams them back out.
//
// Input channel (in_valid/in_ready, value, final_item): one element per
// transaction. Up to MAX_ELEMENTS elements are kept; any beyond that are
// dropped. The transaction that carries final_item starts the sort, and
// in_ready stays low until the last sorted element has been placed in the
// output register.
// Sorting is quicksort with a Lomuto partition (pivot = last element of a
// range), driven by a stack of pending ranges held in a small memory. A
// partition pass over a range of n elements scans n-1 elements; the element
// memory has a single write port, so an exchange takes two writes. Each range
// is also popped, its pivot fetched, the pivot placed and the halves with two
// or more elements pushed; the whole sort does O(n log n) work on typical data
// and O(n^2) on ordered sets.
// Output channel (out_valid/out_ready, sorted_value, end_of_set): each element
// is read from the element memory while the one before it may still wait in the
// output register; a stall holds the output register and the readout waits.
// end_of_set marks the last element. The next set may be loaded while that last element waits.
// Reset (synchronous, active high) empties the set and the range stack;
// memory contents need no clearing.
module quicksort_engine #(
  parameter int unsigned MAX_ELEMENTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value,
  input  logic               final_item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sorted_value,
  output logic               end_of_set
);

  localparam int unsigned IW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned DW = qse_pkg::DATA_W;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);
  localparam logic [IW-1:0] ONE_I = IW'(1);
  localparam logic [IW:0]   ONE_X = (IW+1)'(1);

  // Element memory and range stack memory (one write, one registered read).
  logic signed [DW-1:0] store [MAX_ELEMENTS];
  logic        [2*IW-1:0] stack [MAX_ELEMENTS];

  logic                 st_we;
  logic [IW-1:0]        st_waddr, st_raddr;
  logic signed [DW-1:0] st_wdata, st_rdata;
  logic                 sk_we;
  logic [IW-1:0]        sk_waddr, sk_raddr;
  logic [2*IW-1:0]      sk_wdata, sk_rdata;

  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= st_wdata;
    end
    st_rdata <= store[st_raddr];
  end

  always_ff @(posedge clk) begin
    if (sk_we) begin
      stack[sk_waddr] <= sk_wdata;
    end
    sk_rdata <= stack[sk_raddr];
  end

  // Control and datapath registers.
  qse_pkg::state_t      state, state_next;
  logic [CW-1:0]        count, count_next;
  logic [CW-1:0]        sp, sp_next;
  logic [IW-1:0]        lo, lo_next, hi, hi_next;
  logic [IW-1:0]        j, j_next, boundary, boundary_next;
  logic [IW-1:0]        k, k_next;
  logic signed [DW-1:0] pivot, pivot_next, vj, vj_next, vb, vb_next;
  logic                 out_valid_next;
  logic signed [DW-1:0] sorted_value_next;
  logic                 end_of_set_next;

  logic [CW-1:0] cnt_new;
  logic [CW-1:0] sp_dec;
  logic [IW-1:0] j_inc;
  logic          out_free;
  logic          k_last;

  assign in_ready = (state == qse_pkg::ST_LOAD);
  assign sp_dec   = sp - CW'(1);
  assign j_inc    = j + ONE_I;
  assign out_free = !out_valid || out_ready;
  assign k_last   = ((CW'(k) + CW'(1)) == count);
  assign cnt_new  = (count < MAX_C) ? count + CW'(1) : count;

  // Index of the last stored element, given a count of at least one.
  function automatic logic [IW-1:0] sp_dec_fix(input logic [CW-1:0] n);
    logic [CW-1:0] m;
    m = n - CW'(1);
    return m[IW-1:0];
  endfunction

  always_comb begin
    state_next        = state;
    count_next        = count;
    sp_next           = sp;
    lo_next           = lo;
    hi_next           = hi;
    j_next            = j;
    boundary_next     = boundary;
    k_next            = k;
    pivot_next        = pivot;
    vj_next           = vj;
    vb_next           = vb;
    out_valid_next    = out_ready ? 1'b0 : out_valid;
    sorted_value_next = sorted_value;
    end_of_set_next   = end_of_set;
    st_we             = 1'b0;
    st_waddr          = j;
    st_wdata          = vj;
    st_raddr          = j;
    sk_we             = 1'b0;
    sk_waddr          = sp[IW-1:0];
    sk_wdata          = {lo, hi};
    sk_raddr          = sp_dec[IW-1:0];

    case (state)
      qse_pkg::ST_LOAD: begin
        if (in_valid) begin
          if (count < MAX_C) begin
            st_we    = 1'b1;
            st_waddr = count[IW-1:0];
            st_wdata = value;
          end
          count_next = cnt_new;
          if (final_item) begin
            // The whole set is the first range to partition.
            if (cnt_new >= CW'(2)) begin
              sk_we    = 1'b1;
              sk_waddr = '0;
              sk_wdata = {{IW{1'b0}}, sp_dec_fix(cnt_new)};
              sp_next  = CW'(1);
            end
            state_next = qse_pkg::ST_POP;
          end
        end
      end
      qse_pkg::ST_POP: begin
        if (sp == '0) begin
          k_next     = '0;
          state_next = qse_pkg::ST_ORD;
        end else begin
          sp_next    = sp_dec;
          state_next = qse_pkg::ST_POPW;
        end
      end
      qse_pkg::ST_POPW: begin
        lo_next    = sk_rdata[2*IW-1:IW];
        hi_next    = sk_rdata[IW-1:0];
        st_raddr   = sk_rdata[IW-1:0];
        state_next = qse_pkg::ST_PIV;
      end
      qse_pkg::ST_PIV: begin
        pivot_next    = st_rdata;
        boundary_next = lo;
        j_next        = lo;
        st_raddr      = lo;
        state_next    = qse_pkg::ST_SCAN;
      end
      qse_pkg::ST_SCAN: begin
        vj_next = st_rdata;
        if (j == hi) begin
          st_raddr   = boundary;
          state_next = (boundary == hi) ? qse_pkg::ST_PUSH1 : qse_pkg::ST_FIN;
        end else if (st_rdata < pivot) begin
          if (boundary == j) begin
            // Exchanging an element with itself changes nothing.
            boundary_next = boundary + ONE_I;
            j_next        = j_inc;
            st_raddr      = j_inc;
          end else begin
            st_raddr   = boundary;
            state_next = qse_pkg::ST_SW1;
          end
        end else begin
          j_next   = j_inc;
          st_raddr = j_inc;
        end
      end
      qse_pkg::ST_SW1: begin
        vb_next    = st_rdata;
        st_we      = 1'b1;
        st_waddr   = boundary;
        st_wdata   = vj;
        state_next = qse_pkg::ST_SW2;
      end
      qse_pkg::ST_SW2: begin
        st_we         = 1'b1;
        st_waddr      = j;
        st_wdata      = vb;
        boundary_next = boundary + ONE_I;
        j_next        = j_inc;
        st_raddr      = j_inc;
        state_next    = qse_pkg::ST_SCAN;
      end
      qse_pkg::ST_FIN: begin
        vb_next    = st_rdata;
        st_we      = 1'b1;
        st_waddr   = boundary;
        st_wdata   = pivot;
        state_next = qse_pkg::ST_FIN2;
      end
      qse_pkg::ST_FIN2: begin
        st_we      = 1'b1;
        st_waddr   = hi;
        st_wdata   = vb;
        state_next = qse_pkg::ST_PUSH1;
      end
      qse_pkg::ST_PUSH1: begin
        if ({1'b0, boundary} > ({1'b0, lo} + ONE_X)) begin
          sk_we    = 1'b1;
          sk_wdata = {lo, boundary - ONE_I};
          sp_next  = sp + CW'(1);
        end
        state_next = qse_pkg::ST_PUSH2;
      end
      qse_pkg::ST_PUSH2: begin
        if (({1'b0, boundary} + ONE_X) < {1'b0, hi}) begin
          sk_we    = 1'b1;
          sk_wdata = {boundary + ONE_I, hi};
          sp_next  = sp + CW'(1);
        end
        state_next = qse_pkg::ST_POP;
      end
      qse_pkg::ST_ORD: begin
        st_raddr   = k;
        state_next = qse_pkg::ST_OLD;
      end
      qse_pkg::ST_OLD: begin
        // Keep the address steady so the read data survives a stall.
        st_raddr = k;
        if (out_free) begin
          out_valid_next    = 1'b1;
          sorted_value_next = st_rdata;
          end_of_set_next   = k_last;
          if (k_last) begin
            count_next = '0;
            sp_next    = '0;
            state_next = qse_pkg::ST_LOAD;
          end else begin
            k_next     = k + ONE_I;
            state_next = qse_pkg::ST_ORD;
          end
        end
      end
      default: begin
        state_next = qse_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= qse_pkg::ST_LOAD;
      count     <= '0;
      sp        <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      sp        <= sp_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    lo           <= lo_next;
    hi           <= hi_next;
    j            <= j_next;
    boundary     <= boundary_next;
    k            <= k_next;
    pivot        <= pivot_next;
    vj           <= vj_next;
    vb           <= vb_next;
    sorted_value <= sorted_value_next;
    end_of_set   <= end_of_set_next;
  end

  // Pending ranges are disjoint and hold two or more elements each.
  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= CW'(MAX_ELEMENTS / 2))
    else $error("range stack deeper than the set allows");

  // During a partition pass the boundary never passes the scan index.
  a_scan_order: assert property (@(posedge clk) disable iff (rst)
    (state == qse_pkg::ST_SCAN) |-> (boundary <= j && j <= hi && lo <= boundary))
    else $error("partition indexes out of order");

  // The element count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= MAX_C)
    else $error("element count beyond store depth");

  // A final element closes the input until the sorted set is read out.
  a_final_closes: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && final_item) |=> !in_ready)
    else $error("input still open after the final element");

endmodule

@@ tb/sv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DATA_W = qse_pkg::DATA_W;
  localparam int unsigned MAX_ELEMENTS = 16;
  // Cycles without any transaction before the run is declared hung. The worst
  // case is an already ordered set of MAX_ELEMENTS (quadratic sort) followed by
  // the long receiver hold-off below.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  // Length of the deliberate receiver hold-off, in cycles.
  localparam int unsigned HOLD_CYCLES = 300;
  // Cycles to watch for stray output after the last expected element.
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned RANDOM_ITEMS = 44;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh80000000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fffffff;

  // Shapes of generated sets.
  typedef enum int {
    VAL_RANDOM,
    VAL_CLUSTERED,
    VAL_RISING,
    VAL_FALLING,
    VAL_EXTREME
  } value_style_t;

  typedef struct {
    logic signed [DATA_W-1:0] val;
    logic                     last;
  } sorted_elem_t;

  // Holds the elements of the set being loaded and, once the final element is
  // seen, the ascending order the block must produce for it.
  class sort_scoreboard;
    logic signed [DATA_W-1:0] held_set[$];
    sorted_elem_t             expected_order[$];
    int unsigned              depth;
    int unsigned              mismatches;

    function new(int unsigned store_depth);
      depth = store_depth;
      mismatches = 0;
    endfunction

    // An accepted input transaction. Elements past the store depth are
    // dropped, but a final flag on a dropped element still closes the set.
    function void note_element(logic signed [DATA_W-1:0] v, logic f);
      logic signed [DATA_W-1:0] key;
      int                       i;
      int                       j;
      if (held_set.size() < depth) held_set.push_back(v);
      if (!f) return;
      // Plain insertion sort; the order of equal values does not matter.
      for (i = 1; i < held_set.size(); i++) begin
        key = held_set[i];
        j = i;
        while (j > 0 && held_set[j-1] > key) begin
          held_set[j] = held_set[j-1];
          j--;
        end
        held_set[j] = key;
      end
      for (i = 0; i < held_set.size(); i++) begin
        expected_order.push_back('{val: held_set[i], last: (i == held_set.size() - 1)});
      end
      held_set.delete();
    endfunction

    // An accepted output transaction, compared with the oldest expectation.
    function void check_output(logic signed [DATA_W-1:0] v, logic e);
      sorted_elem_t exp_elem;
      if (expected_order.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output: sorted_value=%0d end_of_set=%b", v, e);
        return;
      end
      exp_elem = expected_order.pop_front();
      if (exp_elem.val !== v || exp_elem.last !== e) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected sorted_value=%0d end_of_set=%b, got %0d %b",
                   exp_elem.val, exp_elem.last, v, e);
      end
    endfunction

    function int unsigned outstanding();
      return expected_order.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] value = '0;
  logic                     final_item = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     end_of_set;

  sort_scoreboard           sb = new(MAX_ELEMENTS);
  logic signed [DATA_W-1:0] set_buf[$];
  bit                       hold_request = 1'b0;
  int unsigned              elements_sent = 0;

  quicksort_engine #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .value(value),
    .final_item(final_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sorted_value(sorted_value),
    .end_of_set(end_of_set)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Idle gap length: mostly none, sometimes short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value(value_style_t style, int idx,
                                                          logic signed [DATA_W-1:0] base);
    case (style)
      VAL_RANDOM:    return $urandom;
      VAL_CLUSTERED: return int'($urandom_range(0, 8)) - 4;
      VAL_RISING:    return base + idx * 7;
      VAL_FALLING:   return base - idx * 7;
      default: begin
        case ($urandom_range(0, 5))
          0:       return VAL_MIN;
          1:       return VAL_MAX;
          2:       return 0;
          3:       return -1;
          4:       return 1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  task automatic build_set(int unsigned n, value_style_t style);
    logic signed [DATA_W-1:0] base;
    base = int'($urandom_range(0, 1000)) - 500;
    set_buf.delete();
    for (int i = 0; i < n; i++) set_buf.push_back(pick_value(style, i, base));
  endtask

  // Offers one element and holds it until the transaction completes. The
  // handshake is sampled right after the edge, before the block's registers
  // update, so in_ready is the value the edge itself saw.
  task automatic send_element(logic signed [DATA_W-1:0] v, logic f, int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    value      <= v;
    final_item <= f;
    do @(posedge clk); while (!in_ready);
    sb.note_element(v, f);
    elements_sent++;
  endtask

  // Sends set_buf as one set, flagging the last element as final.
  task automatic send_set(bit no_gaps);
    for (int i = 0; i < set_buf.size(); i++)
      send_element(set_buf[i], (i == set_buf.size() - 1), no_gaps ? 0 : pick_gap());
  endtask

  // Receiver: random stalls and ready stretches. On request it holds off for
  // a long stretch so the output register stays full and the input stalls.
  initial begin
    int unsigned n;
    bit          hold_done;
    hold_done = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  // Every accepted output transaction is checked against the prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_output(sorted_value, end_of_set);
  end

  // Watchdog: the run is hung if no transaction completes for too long.
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    int unsigned random_start;
    int unsigned n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // A set of one element, which is also the largest value.
    set_buf = '{VAL_MAX};
    send_set(1'b0);

    // Both extremes, zero, plus and minus one, and a repeated minimum.
    set_buf = '{VAL_MIN, VAL_MAX, 0, -1, 1, VAL_MIN};
    send_set(1'b0);

    // A full store in descending order, the worst case for this partition,
    // followed by one more element carrying the final flag. That element is
    // dropped because the store is full, yet it still starts the sort.
    set_buf.delete();
    for (int i = 0; i < MAX_ELEMENTS; i++) set_buf.push_back(VAL_MAX - i * 3);
    set_buf.push_back(VAL_MIN);
    send_set(1'b0);

    // Back-to-back full sets while the receiver holds off, so the block fills
    // up and stalls its input.
    hold_request = 1'b1;
    for (int s = 0; s < 3; s++) begin
      build_set(MAX_ELEMENTS, value_style_t'($urandom_range(0, 4)));
      send_set(1'b1);
    end

    // Random sets, mostly within the store depth, some overflowing it.
    random_start = elements_sent;
    while (elements_sent - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) n = $urandom_range(MAX_ELEMENTS + 1, MAX_ELEMENTS + 4);
      else n = $urandom_range(1, MAX_ELEMENTS);
      build_set(n, value_style_t'($urandom_range(0, 4)));
      send_set($urandom_range(0, 4) == 0);
    end
    in_valid <= 1'b0;

    // Wait for every predicted element, then watch for anything extra.
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/qse_pkg.sv
src/quicksort_engine.sv
tb/sv/tb_top.sv
